/* hw/rtl/mrk_pkg.sv */
`default_nettype none
package mrk_pkg;
    localparam int MaxRows   = 64;
    localparam int MaxCols   = 64;
    localparam int RowW      = 7;
    localparam int ColW      = 7;
    localparam int ValW      = 13;
    localparam int CntW      = 13;
    localparam int TabStride = MaxCols + 1;
    localparam int TabDepth  = (MaxRows + 1) * (MaxCols + 1);
    localparam int AddrW     = $clog2(TabDepth);

    localparam logic [1:0] RegRowCount = 2'd0;
    localparam logic [1:0] RegColCount = 2'd1;
    localparam logic [1:0] RegMaxOnes  = 2'd2;

    // table read selector for the datapath
    typedef enum logic [2:0] {
        t_rd_a = 3'd0,  // (r, c) during load, (bottom, right) in search
        t_rd_b = 3'd1,  // (r-1, c) / (top-1, right)
        t_rd_c = 3'd2,  // (r, c-1) / (bottom, left-1)
        t_rd_d = 3'd3   // (top-1, left-1)
    } t_rdsel;

    typedef struct packed {
        logic   clr_load;    // restart load position
        logic   load_step;   // write the load sum and advance position
        logic   rd_en;
        t_rdsel rd_sel;
        logic   cap;         // capture registered read data into selected slot
        t_rdsel cap_sel;
        logic   srch_init;   // top=1, bottom=1, best=0
        logic   pair_init;   // left=1, right=1
        logic   left_inc;
        logic   right_inc;   // evaluate area, next right
        logic   bottom_inc;
        logic   top_inc;
    } t_cmd;

    typedef struct packed {
        logic last_cell;     // current load position is the last of the grid
        logic left_le_right;
        logic over;          // rectangle ones > max_ones
        logic right_last;
        logic bottom_last;
        logic top_last;
    } t_sts;

    function automatic logic [RowW-1:0] clamp_dim(input logic [6:0] v, input int lim);
        logic [RowW-1:0] res;
        if (v == 7'd0) res = RowW'(1);
        else if (int'(v) > lim) res = RowW'(lim);
        else res = v[RowW-1:0];
        return res;
    endfunction
endpackage
`default_nettype wire

/* hw/rtl/mrk_datapath.sv */
`default_nettype none
module mrk_datapath (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire mrk_pkg::t_cmd             i_cmd,
    output mrk_pkg::t_sts                  o_sts,
    input  wire logic                      i_cell_bit,
    input  wire logic [mrk_pkg::RowW-1:0]  i_rows,
    input  wire logic [mrk_pkg::ColW-1:0]  i_cols,
    input  wire logic [mrk_pkg::ValW-1:0]  i_max_ones,
    output logic      [mrk_pkg::ValW-1:0]  o_best
);
    import mrk_pkg::*;

    logic [ValW-1:0] r_mem [TabDepth];
    logic [ValW-1:0] r_rdata;
    logic [RowW-1:0] r_lr, r_top, r_bot;
    logic [ColW-1:0] r_lc, r_left, r_right;
    logic [ValW-1:0] r_va, r_vb, r_vc, r_vd, r_best;
    logic [RowW-1:0] rt1;
    logic [ColW-1:0] rl1;
    logic [AddrW-1:0] rd_addr, wr_addr;
    logic [ValW-1:0] ld_sum, ones;
    logic [ValW+RowW-1:0] area;
    logic [ColW-1:0] width;
    logic [RowW-1:0] height;

    // border: row 0 or col 0 read as zero, never stored
    function automatic logic [AddrW-1:0] adr(input logic [RowW-1:0] r,
                                             input logic [ColW-1:0] c);
        return AddrW'(r * TabStride + c);
    endfunction

    logic rd_zero, r_rd_zero;

    assign rt1 = r_top - RowW'(1);
    assign rl1 = r_left - ColW'(1);

    always_comb begin
        rd_addr = '0;
        rd_zero = 1'b0;
        case (i_cmd.rd_sel)
            t_rd_a: begin
                rd_addr = adr(r_bot, r_right);
                rd_zero = (r_bot == '0);
            end
            t_rd_b: begin
                rd_addr = adr(rt1, r_right);
                rd_zero = (rt1 == '0);
            end
            t_rd_c: begin
                rd_addr = adr(r_bot, rl1);
                rd_zero = (rl1 == '0);
            end
            t_rd_d: begin
                rd_addr = adr(rt1, rl1);
                rd_zero = (rt1 == '0) || (rl1 == '0);
            end
            default: begin
                rd_addr = '0;
                rd_zero = 1'b1;
            end
        endcase
    end

    assign wr_addr = adr(r_lr, r_lc);
    // during load the search row registers hold the load neighbors:
    // bot=r, top-1=r-1, right=c, left-1=c-1 ; sum = bit + (r-1,c) + (r,c-1) - (r-1,c-1)
    assign ld_sum = ValW'(i_cell_bit) + r_vb + r_vc - r_vd;
    assign ones = r_va - r_vb - r_vc + r_vd;
    assign width = r_right + ColW'(1) - r_left;
    assign height = r_bot - r_top + RowW'(1);
    assign area = height * width;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_step) r_mem[wr_addr] <= ld_sum;
        if (i_cmd.rd_en) begin
            r_rdata   <= r_mem[rd_addr];
            r_rd_zero <= rd_zero;
        end
        if (i_cmd.cap) begin
            case (i_cmd.cap_sel)
                t_rd_a: r_va <= r_rd_zero ? '0 : r_rdata;
                t_rd_b: r_vb <= r_rd_zero ? '0 : r_rdata;
                t_rd_c: r_vc <= r_rd_zero ? '0 : r_rdata;
                t_rd_d: r_vd <= r_rd_zero ? '0 : r_rdata;
                default: r_va <= r_va;
            endcase
        end
    end

    // load position (r_lr,r_lc) 1-based; search pointers double as load neighbors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_load) begin
            r_lr <= RowW'(1);
            r_lc <= ColW'(1);
        end else if (i_cmd.load_step) begin
            if (r_lc == i_cols) begin
                r_lc <= ColW'(1);
                r_lr <= r_lr + RowW'(1);
            end else begin
                r_lc <= r_lc + ColW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best  <= '0;
            r_top   <= RowW'(1);
            r_bot   <= RowW'(1);
            r_left  <= ColW'(1);
            r_right <= ColW'(1);
        end else if (i_cmd.srch_init) begin
            r_best <= '0;
            r_top  <= RowW'(1);
            r_bot  <= RowW'(1);
        end else if (i_cmd.pair_init) begin
            r_left  <= ColW'(1);
            r_right <= ColW'(1);
        end else if (i_cmd.left_inc) begin
            r_left <= r_left + ColW'(1);
        end else if (i_cmd.right_inc) begin
            if (ValW'(area) > r_best) r_best <= ValW'(area);
            r_right <= r_right + ColW'(1);
        end else if (i_cmd.bottom_inc) begin
            r_bot <= r_bot + RowW'(1);
        end else if (i_cmd.top_inc) begin
            r_top <= r_top + RowW'(1);
            r_bot <= r_top + RowW'(1);
        end else if (!i_cmd.rd_en && !i_cmd.cap) begin
            // load neighbor setup: bot=r, top=r so top-1=r-1, right=c, left=c
            r_bot   <= r_lr;
            r_top   <= r_lr;
            r_right <= r_lc;
            r_left  <= r_lc;
        end
    end

    assign o_sts.last_cell     = (r_lr == i_rows) && (r_lc == i_cols);
    assign o_sts.left_le_right = (r_left <= r_right);
    assign o_sts.over          = (ones > i_max_ones);
    assign o_sts.right_last    = (r_right == i_cols);
    assign o_sts.bottom_last   = (r_bot == i_rows);
    assign o_sts.top_last      = (r_top == i_rows);
    assign o_best = r_best;
endmodule
`default_nettype wire

/* hw/rtl/mrk_ctrl.sv */
`default_nettype none
module mrk_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_wr,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output mrk_pkg::t_cmd       o_cmd,
    input  wire mrk_pkg::t_sts  i_sts
);
    import mrk_pkg::*;

    typedef enum logic [9:0] {
        t_setup = 10'b0000000001,  // latch load neighbors
        t_lrd   = 10'b0000000010,  // read three neighbors
        t_idle  = 10'b0000000100,  // wait for the item
        t_sinit = 10'b0000001000,
        t_pinit = 10'b0000010000,
        t_rd    = 10'b0000100000,  // read four corners
        t_eval  = 10'b0001000000,
        t_next  = 10'b0010000000,
        t_pair  = 10'b0100000000,
        t_out   = 10'b1000000000
    } t_state;

    t_state r_st, n_st;
    logic [2:0] r_k, n_k;  // read/capture sequence step

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= t_setup;
            r_k  <= '0;
        end else begin
            r_st <= n_st;
            r_k  <= n_k;
        end
    end

    always_comb begin
        n_st = r_st;
        n_k  = r_k;
        o_cmd = '0;
        o_cmd.rd_sel  = t_rd_a;
        o_cmd.cap_sel = t_rd_a;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_st)
            t_setup: begin
                // idle datapath cmd latches neighbors from load position
                n_k = '0;
                n_st = t_lrd;
            end
            t_lrd: begin
                // reads b,c,d in steps 0..2, captures each in the next step
                o_cmd.rd_en = (r_k < 3'd3);
                o_cmd.rd_sel = t_rdsel'(r_k + 3'd1);
                o_cmd.cap = (r_k != 3'd0);
                o_cmd.cap_sel = t_rdsel'(r_k);
                n_k = r_k + 3'd1;
                if (r_k == 3'd3) n_st = t_idle;
            end
            t_idle: begin
                o_in_stall = 1'b0;
                o_cmd.cap = 1'b1;  // keep datapath from re-latching neighbors
                o_cmd.cap_sel = t_rd_a;
                o_cmd.rd_en = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_step = 1'b1;
                    if (i_sts.last_cell) begin
                        o_cmd.clr_load = 1'b1;
                        n_st = t_sinit;
                    end else begin
                        n_st = t_setup;
                    end
                end
            end
            t_sinit: begin
                o_cmd.srch_init = 1'b1;
                n_st = t_pinit;
            end
            t_pinit: begin
                o_cmd.pair_init = 1'b1;
                n_k = '0;
                n_st = t_rd;
            end
            t_rd: begin
                o_cmd.rd_en = (r_k < 3'd4);
                o_cmd.rd_sel = t_rdsel'(r_k);
                o_cmd.cap = (r_k != 3'd0);
                o_cmd.cap_sel = t_rdsel'(r_k - 3'd1);
                n_k = r_k + 3'd1;
                if (r_k == 3'd4) n_st = t_eval;
            end
            t_eval: begin
                n_k = '0;
                if (i_sts.left_le_right && i_sts.over) begin
                    o_cmd.left_inc = 1'b1;
                    n_st = t_rd;
                end else begin
                    o_cmd.right_inc = 1'b1;
                    n_st = i_sts.right_last ? t_pair : t_rd;
                end
            end
            t_pair: begin
                if (!i_sts.bottom_last) begin
                    o_cmd.bottom_inc = 1'b1;
                    n_st = t_pinit;
                end else if (!i_sts.top_last) begin
                    o_cmd.top_inc = 1'b1;
                    n_st = t_pinit;
                end else begin
                    n_st = t_out;
                end
            end
            t_out: begin
                o_out_valid = 1'b1;
                o_cmd.cap = 1'b1;
                if (!i_out_stall) n_st = t_setup;
            end
            default: n_st = t_setup;
        endcase
        if (i_cfg_wr) begin
            // a register write restarts the grid, so no item is taken this cycle
            o_cmd.clr_load = 1'b1;
            o_in_stall = 1'b1;
            if (r_st == t_setup || r_st == t_lrd || r_st == t_idle) begin
                n_st = t_setup;
                o_cmd.load_step = 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/max_rectangle_at_most_k_ones.sv */
// after the last cell, the search is set up once; then for each row pair the pointers
// are initialised and the four corners are read and evaluated for each right-column step
// and each left-pointer move; then the single result is offered and held until taken
// during load, no new item is taken while the prior one's neighbors use the single read port
// reset: synchronous active low; registers 64/64/0, load position at row 1 col 1
`default_nettype none
module max_rectangle_at_most_k_ones (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [3:0]               paddr,
    input  wire logic [31:0]              pwdata,
    output logic      [31:0]              prdata,
    output logic                          pready,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic                     i_cell_bit,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic      [mrk_pkg::ValW-1:0] o_best_area
);
    import mrk_pkg::*;

    logic [6:0]      r_row_count, r_col_count;
    logic [ValW-1:0] r_max_ones;
    logic            cfg_wr;
    logic [1:0]      reg_idx;
    t_cmd            cmd;
    t_sts            sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    // any write, known address or not, is only a register update when it hits one
    assign cfg_wr  = psel && penable && pwrite
                   && (reg_idx == RegRowCount || reg_idx == RegColCount
                       || reg_idx == RegMaxOnes);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= 7'd64;
            r_col_count <= 7'd64;
            r_max_ones  <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                RegRowCount: r_row_count <= pwdata[6:0];
                RegColCount: r_col_count <= pwdata[6:0];
                RegMaxOnes:  r_max_ones  <= pwdata[ValW-1:0];
                default:     r_max_ones  <= r_max_ones;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            RegRowCount: prdata = {25'd0, r_row_count};
            RegColCount: prdata = {25'd0, r_col_count};
            RegMaxOnes:  prdata = {19'd0, r_max_ones};
            default:     prdata = '0;
        endcase
    end

    mrk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (cfg_wr),
        .i_in_valid  (i_valid),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .i_out_stall (i_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    mrk_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_cell_bit (i_cell_bit),
        .i_rows     (clamp_dim(r_row_count, MaxRows)),
        .i_cols     (clamp_dim(r_col_count, MaxCols)),
        .i_max_ones (r_max_ones),
        .o_best     (o_best_area)
    );
endmodule
`default_nettype wire

/* hw/rtl/mrk_checker.sv */
`default_nettype none
module mrk_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [12:0] o_best_area
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_best_area))
        else $error("result dropped while stalled");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while result pending");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_best_area <= 13'd4096)
        else $error("area out of range");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result after reset");
endmodule

bind max_rectangle_at_most_k_ones mrk_checker u_chk (.*);
`default_nettype wire

/* tb/tb_max_rectangle_at_most_k_ones.sv */
`default_nettype none
module tb_max_rectangle_at_most_k_ones;
    import mrk_pkg::*;

    localparam logic [3:0] AddrRows = 4'(RegRowCount) << 2;
    localparam logic [3:0] AddrCols = 4'(RegColCount) << 2;
    localparam logic [3:0] AddrOnes = 4'(RegMaxOnes) << 2;

    logic            i_clk;
    logic            i_rst_n;
    logic            psel;
    logic            penable;
    logic            pwrite;
    logic [3:0]      paddr;
    logic [31:0]     pwdata;
    logic [31:0]     prdata;
    logic            pready;
    logic            i_valid;
    logic            o_stall;
    logic            i_cell_bit;
    logic            o_valid;
    logic            i_stall;
    logic [ValW-1:0] o_best_area;

    max_rectangle_at_most_k_ones dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall), .i_cell_bit(i_cell_bit),
        .o_valid(o_valid), .i_stall(i_stall), .o_best_area(o_best_area)
    );

    // shadow of the configuration registers and the load position
    logic [6:0]      shadow_rows;
    logic [6:0]      shadow_cols;
    logic [12:0]     shadow_max_ones;
    int              cells_in_grid;
    bit              grid_bits [0:MaxRows*MaxCols-1];
    logic [ValW-1:0] area_q [$];

    int  errors;
    int  cells_sent;
    int  grids_done;
    bit  no_idle;        // last part of the run: no gaps on either side
    bit  long_hold_req;  // ask the receiver for a long hold-off

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // generous fixed limit
    initial begin
        #(4 * 3000000);
        $display("tb_max_rectangle_at_most_k_ones: done, errors");
        $finish;
    end

    function automatic int clamp_size(logic [6:0] v);
        if (v == 7'd0) return 1;
        if (int'(v) > MaxRows) return MaxRows;
        return int'(v);
    endfunction

    // prefix sums over the loaded grid, then the two-pointer sweep per row pair
    function automatic logic [ValW-1:0] largest_area(int rows, int cols);
        int ps [0:MaxRows][0:MaxCols];
        int best;
        int lp;
        int ones;
        int area;
        for (int r = 0; r <= rows; r++)
            for (int c = 0; c <= cols; c++)
                ps[r][c] = 0;
        for (int r = 1; r <= rows; r++)
            for (int c = 1; c <= cols; c++)
                ps[r][c] = int'(grid_bits[(r-1)*MaxCols + c-1]) + ps[r-1][c]
                         + ps[r][c-1] - ps[r-1][c-1];
        best = 0;
        for (int t = 1; t <= rows; t++)
            for (int b = t; b <= rows; b++) begin
                lp = 1;
                for (int rt = 1; rt <= cols; rt++) begin
                    while (lp <= rt) begin
                        ones = ps[b][rt] - ps[t-1][rt] - ps[b][lp-1] + ps[t-1][lp-1];
                        if (ones > int'(shadow_max_ones)) lp++;
                        else break;
                    end
                    area = (b - t + 1) * (rt + 1 - lp);
                    if (area > best) best = area;
                end
            end
        return ValW'(best);
    endfunction

    // track one accepted cell; the last cell of a grid yields one expected area
    task automatic take_cell(bit b);
        int rows;
        int cols;
        rows = clamp_size(shadow_rows);
        cols = clamp_size(shadow_cols);
        if (cells_in_grid >= rows * cols) cells_in_grid = 0;
        grid_bits[(cells_in_grid / cols) * MaxCols + cells_in_grid % cols] = b;
        cells_in_grid++;
        if (cells_in_grid == rows * cols) begin
            area_q.push_back(largest_area(rows, cols));
            cells_in_grid = 0;
            grids_done++;
        end
    endtask

    // offer one item, with a random gap first unless idling is off
    task automatic send_cell(bit b);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cell_bit <= b;
        do @(posedge i_clk); while (o_stall);
        take_cell(b);
        cells_sent++;
    endtask

    task automatic stop_sending();
        i_valid <= 1'b0;
    endtask

    // wait for every expected area, then let the search of a partial grid drain
    task automatic wait_drained();
        stop_sending();
        while (area_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [3:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            AddrRows: shadow_rows     = value[6:0];
            AddrCols: shadow_cols     = value[6:0];
            AddrOnes: shadow_max_ones = value[12:0];
            default: ;
        endcase
        cells_in_grid = 0;
    endtask

    task automatic cfg_check(logic [3:0] addr, logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata != want) begin
            $display("%0t: readback addr %0d expected %0d actual %0d",
                     $time, addr, want, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_grid(int rows, int cols, int max_ones);
        cfg_write(AddrRows, 32'(rows));
        cfg_write(AddrCols, 32'(cols));
        cfg_write(AddrOnes, 32'(max_ones));
    endtask

    task automatic send_grid(int n, int density);
        for (int i = 0; i < n; i++)
            send_cell($urandom_range(0, 99) < density);
    endtask

    // receiver: random stall bursts, plus a long hold-off on request
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (long_hold_req) begin
            i_stall       <= 1'b1;
            stall_left    <= 400;
            long_hold_req <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 7);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // compare each accepted area with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (area_q.size() == 0) begin
                $display("%0t: unexpected area, expected none actual %0d",
                         $time, o_best_area);
                errors++;
            end else begin
                if (o_best_area != area_q[0]) begin
                    $display("%0t: best_area expected %0d actual %0d",
                             $time, area_q[0], o_best_area);
                    errors++;
                end
                void'(area_q.pop_front());
            end
        end
    end

    // smallest grids, all-clear and all-set cells, sizes of zero, huge limits
    task automatic test_extremes();
        set_grid(1, 1, 0);
        send_cell(1'b0);
        send_cell(1'b1);
        wait_drained();
        set_grid(0, 0, 8191);
        send_cell(1'b1);
        wait_drained();
        set_grid(3, 3, 0);
        send_grid(9, 0);
        send_grid(9, 100);
        wait_drained();
        cfg_write(AddrOnes, 32'd4096);
        send_grid(9, 100);
        wait_drained();
        cfg_check(AddrRows, 32'd3);
        cfg_check(AddrCols, 32'd3);
        cfg_check(AddrOnes, 32'd4096);
    endtask

    // a register write in the middle of a grid restarts loading
    task automatic test_restart_on_write();
        set_grid(3, 3, 2);
        send_grid(4, 50);
        wait_drained();
        cfg_write(AddrOnes, 32'd1);
        send_grid(9, 50);
        wait_drained();
    endtask

    // sizes above the maximum saturate; one long and two tall grids
    task automatic test_size_limits();
        set_grid(127, 1, 3);
        send_grid(64, 30);
        wait_drained();
        set_grid(1, 100, 5);
        send_grid(64, 30);
        wait_drained();
        set_grid(64, 2, 10);
        send_grid(128, 20);
        wait_drained();
    endtask

    // many small grids with random sizes, densities and limits
    task automatic test_random_grids(int cell_budget);
        int start;
        int rows;
        int cols;
        int k;
        start = cells_sent;
        while (cells_sent - start < cell_budget) begin
            rows = $urandom_range(1, 8);
            cols = $urandom_range(1, 8);
            case ($urandom_range(0, 4))
                0: k = 0;
                1: k = rows * cols;
                2: k = $urandom_range(rows * cols, 8191);
                default: k = $urandom_range(0, rows * cols);
            endcase
            set_grid(rows, cols, k);
            repeat ($urandom_range(1, 3)) send_grid(rows * cols, $urandom_range(0, 100));
            wait_drained();
        end
    endtask

    // receiver holds off while several grids are offered, then sender pauses
    task automatic test_backpressure();
        set_grid(2, 2, 1);
        long_hold_req <= 1'b1;
        repeat (5) send_grid(4, 50);
        wait_drained();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_valid       = 1'b0;
        i_cell_bit    = 1'b0;
        i_stall       = 1'b0;
        errors        = 0;
        cells_sent    = 0;
        grids_done    = 0;
        no_idle       = 1'b0;
        long_hold_req = 1'b0;
        shadow_rows     = 7'd64;
        shadow_cols     = 7'd64;
        shadow_max_ones = 13'd0;
        cells_in_grid   = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_restart_on_write();
        test_size_limits();
        test_random_grids(100);
        test_backpressure();
        no_idle = 1'b1;
        test_random_grids(60);

        $display("covered %0d cells in %0d grids: size limits, restart on write,",
                 cells_sent, grids_done);
        $display("random sizes and limits, long output hold-off and gap-free traffic");
        if (errors == 0 && area_q.size() == 0) begin
            $display("tb_max_rectangle_at_most_k_ones: done, clean");
        end else begin
            $display("tb_max_rectangle_at_most_k_ones: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
